// ----- src/prc_pkg.sv -----
// Shared types, widths and constants of the PageRank power-iteration core.
`timescale 1ns / 1ps
package prc_pkg;

  localparam int NODE_MAX_DEF = 1024;
  localparam int EDGE_MAX_DEF = 8192;

  localparam int MODE_W  = 3;
  localparam int NODE_W  = 10;
  localparam int RANK_W  = 32;
  localparam int DEG_W   = 14;
  localparam int ITER_W  = 16;
  localparam int BETA_W  = 16;
  localparam int NCNT_W  = 11;
  localparam int THR_W   = 64;
  localparam int INDEX_W = 2;

  localparam logic [DEG_W-1:0]  DEG_SAT  = 14'h3FFF;
  localparam logic [BETA_W-1:0] BETA_ONE = 16'd32768;

  localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 11'd1024;
  localparam logic [BETA_W-1:0] DAMPING_RST    = 16'd27853;
  localparam logic [ITER_W-1:0] ITER_LIMIT_RST = 16'd100;
  localparam logic [THR_W-1:0]  THRESHOLD_RST  = 64'd0;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  typedef enum logic [INDEX_W-1:0] {
    REG_NODE_COUNT,
    REG_DAMPING,
    REG_ITER_LIMIT,
    REG_THRESHOLD
  } reg_index_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_EDGE,
    MODE_LOAD_RANK,
    MODE_RUN,
    MODE_READ_RANK,
    MODE_CLEAR
  } mode_t;

  typedef enum logic [4:0] {
    S_CLR_ALL,
    S_CLR_DEG,
    S_IDLE,
    S_DEG_INC,
    S_READ,
    S_A_RD,
    S_A_CHK,
    S_A_DIV,
    S_B_DEAD,
    S_B_DEADW,
    S_B_TEL,
    S_B_TELW,
    S_C_RD,
    S_C_FETCH,
    S_C_ADD,
    S_D_RD,
    S_D_SUM,
    S_D_MUL,
    S_D_NEW,
    S_D_DIFF,
    S_D_SQ,
    S_D_ACC,
    S_ITER,
    S_REPORT
  } state_t;

endpackage

// ----- src/prc_divider.sv -----
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module prc_divider import prc_pkg::*; #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   trial;
  logic             fits;

  // The quotient register first holds the dividend and shifts it out MSB first.
  assign trial = {rem, quotient[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        cnt      <= CNT_W'(NUM_W);
        rem      <= '0;
        den      <= denom;
        quotient <= numer;
      end else if (running) begin
        rem      <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        quotient <= {quotient[NUM_W-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/pagerank_power_iteration_core.sv -----
// Top level of the PageRank power-iteration core: sequencer, graph stores and datapath.
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------------------------------
//   request   | start, busy          | mode, first_node, second_node, rank_in
//   result    | result_valid strobe  | kind, node_out, rank_out, iterations_used,
//             |                      | converged, overflow
//   config    | write_enable         | reg_index, write_data
//
// A rank load is taken in the idle state without raising busy; an edge load then updates the
// source's degree (not when it is dropped); a rank read answers in the cycle after the request;
// a clear zeroes every degree entry. A run forms each node's share with the serial divider,
// then walks the edges and the nodes to spread the shares and form the new ranks.
// After reset the degree and rank stores are cleared while busy is high.
// Results are strobed for one cycle; the receiver cannot stall them.
`timescale 1ns / 1ps
module pagerank_power_iteration_core import prc_pkg::*; #(
  parameter int NODE_MAX = NODE_MAX_DEF,
  parameter int EDGE_MAX = EDGE_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [MODE_W-1:0]  mode,
  input  logic [NODE_W-1:0]  first_node,
  input  logic [NODE_W-1:0]  second_node,
  input  logic [RANK_W-1:0]  rank_in,
  input  logic               write_enable,
  input  logic [INDEX_W-1:0] reg_index,
  input  logic [THR_W-1:0]   write_data,
  output logic               result_valid,
  output logic               kind,
  output logic [NODE_W-1:0]  node_out,
  output logic [RANK_W-1:0]  rank_out,
  output logic [ITER_W-1:0]  iterations_used,
  output logic               converged,
  output logic               overflow
);

  localparam int NAW = $clog2(NODE_MAX);
  localparam int NCW = $clog2(NODE_MAX + 1);
  localparam int EAW = (EDGE_MAX > 1) ? $clog2(EDGE_MAX) : 1;
  localparam int ETW = $clog2(EDGE_MAX + 1);
  localparam int AW  = RANK_W + ETW + 1;
  localparam int DSW = RANK_W + NAW;
  localparam int DVW = (NCW > DEG_W) ? NCW : DEG_W;
  localparam int PW  = AW + BETA_W;
  localparam int NVW = PW - 15 + 1;
  localparam logic [31:0] NMAX = 32'(NODE_MAX);
  localparam logic [31:0] EMAX = 32'(EDGE_MAX);

  state_t state, state_next;

  logic [NCNT_W-1:0] node_count;
  logic [BETA_W-1:0] damping_factor;
  logic [ITER_W-1:0] iteration_limit;
  logic [THR_W-1:0]  convergence_threshold;

  logic [ETW-1:0]    edge_total;
  logic              overflow_flag;
  logic [ITER_W-1:0] last_iterations;
  logic              last_converged;

  logic [NCW-1:0]    i;
  logic [ETW-1:0]    e;
  logic [ITER_W-1:0] iters;
  logic [NODE_W-1:0] a_reg;
  logic              a_ok;
  logic [DSW-1:0]    dead_sum;
  logic [RANK_W-1:0] dead;
  logic [RANK_W-1:0] teleport;
  logic [THR_W-1:0]  diff_sum;
  logic [AW-1:0]     sum_reg;
  logic [PW-1:0]     prod;
  logic [RANK_W-1:0] v_reg;
  logic [RANK_W-1:0] old_rank;
  logic [RANK_W-1:0] d_reg;
  logic [THR_W-1:0]  sq_reg;

  logic [2*NODE_W-1:0] edge_mem  [EDGE_MAX];
  logic [DEG_W-1:0]    deg_mem   [NODE_MAX];
  logic [RANK_W-1:0]   rank_mem  [NODE_MAX];
  logic [RANK_W-1:0]   share_mem [NODE_MAX];
  logic [AW-1:0]       acc_mem   [NODE_MAX];

  logic [2*NODE_W-1:0] edge_rd;
  logic [DEG_W-1:0]    deg_rd;
  logic [RANK_W-1:0]   rank_rd;
  logic [RANK_W-1:0]   share_rd;
  logic [AW-1:0]       acc_rd;

  logic              edge_we;
  logic [EAW-1:0]    edge_ra;
  logic              deg_we;
  logic [NAW-1:0]    deg_wa, deg_ra;
  logic [DEG_W-1:0]  deg_wd;
  logic              rank_we;
  logic [NAW-1:0]    rank_wa, rank_ra;
  logic [RANK_W-1:0] rank_wd;
  logic              share_we;
  logic [RANK_W-1:0] share_wd;
  logic [NAW-1:0]    share_ra;
  logic              acc_we;
  logic [NAW-1:0]    acc_wa, acc_ra;
  logic [AW-1:0]     acc_wd;

  logic           div_start, div_done;
  logic [DSW-1:0] div_num, div_q;
  logic [DVW-1:0] div_den;

  logic [NCNT_W-1:0] nc_nz;
  logic [31:0]       n_wide;
  logic [NCW-1:0]    n;
  logic [BETA_W-1:0] beta;
  logic [ITER_W-1:0] limit;
  logic [NAW-1:0]    node_addr;
  logic              a_in, b_in, accept, i_last, e_last, clr_last, edge_ok;
  logic [NODE_W-1:0] es, et;
  logic [NVW-1:0]    v_sum;
  logic [THR_W:0]    diff_add;
  logic [ITER_W-1:0] iters_inc;

  // Effective settings: zero counts act as one, oversized values are clamped.
  assign nc_nz  = (node_count == '0) ? NCNT_W'(1) : node_count;
  assign n_wide = (32'(nc_nz) > NMAX) ? NMAX : 32'(nc_nz);
  assign n      = n_wide[NCW-1:0];
  assign beta   = (damping_factor > BETA_ONE) ? BETA_ONE : damping_factor;
  assign limit  = (iteration_limit == '0) ? ITER_W'(1) : iteration_limit;

  assign node_addr = NAW'(first_node);
  assign a_in      = 32'(first_node) < NMAX;
  assign b_in      = 32'(second_node) < NMAX;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign i_last    = (i + NCW'(1)) == n;
  assign e_last    = (e + ETW'(1)) == edge_total;
  assign clr_last  = i == NCW'(NODE_MAX - 1);
  assign es        = edge_rd[2*NODE_W-1:NODE_W];
  assign et        = edge_rd[NODE_W-1:0];
  assign edge_ok   = (32'(es) < 32'(n)) && (32'(et) < 32'(n));
  assign v_sum     = NVW'(prod[PW-1:15]) + NVW'(teleport);
  assign diff_add  = {1'b0, diff_sum} + {1'b0, sq_reg};
  assign iters_inc = iters + ITER_W'(1);

  prc_divider #(
    .NUM_W(DSW),
    .DEN_W(DVW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .numer   (div_num),
    .denom   (div_den),
    .done    (div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR_ALL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    edge_we    = 1'b0;
    edge_ra    = e[EAW-1:0];
    deg_we     = 1'b0;
    deg_wa     = i[NAW-1:0];
    deg_wd     = '0;
    deg_ra     = i[NAW-1:0];
    rank_we    = 1'b0;
    rank_wa    = i[NAW-1:0];
    rank_wd    = '0;
    rank_ra    = i[NAW-1:0];
    share_we   = 1'b0;
    share_wd   = '0;
    share_ra   = NAW'(es);
    acc_we     = 1'b0;
    acc_wa     = i[NAW-1:0];
    acc_wd     = '0;
    acc_ra     = i[NAW-1:0];
    div_start  = 1'b0;
    div_num    = DSW'(rank_rd);
    div_den    = DVW'(deg_rd);
    case (state)
      S_CLR_ALL: begin
        deg_we  = 1'b1;
        rank_we = 1'b1;
        if (clr_last) state_next = S_IDLE;
      end
      S_CLR_DEG: begin
        deg_we = 1'b1;
        if (clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        deg_ra  = node_addr;
        rank_ra = node_addr;
        if (accept) begin
          case (mode)
            MODE_LOAD_EDGE: begin
              if (a_in && b_in && (32'(edge_total) < EMAX)) begin
                edge_we    = 1'b1;
                state_next = S_DEG_INC;
              end
            end
            MODE_LOAD_RANK: begin
              rank_we = a_in;
              rank_wa = node_addr;
              rank_wd = rank_in;
            end
            MODE_RUN:       state_next = S_A_RD;
            MODE_READ_RANK: state_next = S_READ;
            MODE_CLEAR:     state_next = S_CLR_DEG;
            default:        state_next = S_IDLE;
          endcase
        end
      end
      S_DEG_INC: begin
        deg_we     = 1'b1;
        deg_wa     = NAW'(a_reg);
        deg_wd     = (deg_rd == DEG_SAT) ? deg_rd : deg_rd + DEG_W'(1);
        state_next = S_IDLE;
      end
      S_READ:   state_next = S_IDLE;
      S_A_RD:   state_next = S_A_CHK;
      S_A_CHK: begin
        if (deg_rd == '0) begin
          share_we   = 1'b1;
          acc_we     = 1'b1;
          state_next = i_last ? S_B_DEAD : S_A_RD;
        end else begin
          div_start  = 1'b1;
          state_next = S_A_DIV;
        end
      end
      S_A_DIV: begin
        if (div_done) begin
          share_we   = 1'b1;
          share_wd   = div_q[RANK_W-1:0];
          acc_we     = 1'b1;
          state_next = i_last ? S_B_DEAD : S_A_RD;
        end
      end
      S_B_DEAD: begin
        div_start  = 1'b1;
        div_num    = dead_sum;
        div_den    = DVW'(n);
        state_next = S_B_DEADW;
      end
      S_B_DEADW: if (div_done) state_next = S_B_TEL;
      S_B_TEL: begin
        div_start  = 1'b1;
        div_num    = DSW'({BETA_ONE - beta, 16'd0});
        div_den    = DVW'(n);
        state_next = S_B_TELW;
      end
      S_B_TELW: begin
        if (div_done) state_next = (edge_total != '0) ? S_C_RD : S_D_RD;
      end
      S_C_RD:    state_next = S_C_FETCH;
      S_C_FETCH: begin
        acc_ra     = NAW'(et);
        state_next = S_C_ADD;
      end
      S_C_ADD: begin
        acc_we     = edge_ok;
        acc_wa     = NAW'(et);
        acc_wd     = acc_rd + AW'(share_rd);
        state_next = e_last ? S_D_RD : S_C_RD;
      end
      S_D_RD:   state_next = S_D_SUM;
      S_D_SUM:  state_next = S_D_MUL;
      S_D_MUL:  state_next = S_D_NEW;
      S_D_NEW:  state_next = S_D_DIFF;
      S_D_DIFF: begin
        rank_we    = 1'b1;
        rank_wd    = v_reg;
        state_next = S_D_SQ;
      end
      S_D_SQ:   state_next = S_D_ACC;
      S_D_ACC:  state_next = i_last ? S_ITER : S_D_RD;
      S_ITER: begin
        if ((iters_inc >= limit) || (diff_sum <= convergence_threshold)) begin
          state_next = S_REPORT;
        end else begin
          state_next = S_A_RD;
        end
      end
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Stores: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_total[EAW-1:0]] <= {first_node, second_node};
    edge_rd <= edge_mem[edge_ra];
  end

  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_rd <= deg_mem[deg_ra];
  end

  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
    rank_rd <= rank_mem[rank_ra];
  end

  always_ff @(posedge clk) begin
    if (share_we) share_mem[i[NAW-1:0]] <= share_wd;
    share_rd <= share_mem[share_ra];
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    acc_rd <= acc_mem[acc_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count            <= NODE_COUNT_RST;
      damping_factor        <= DAMPING_RST;
      iteration_limit       <= ITER_LIMIT_RST;
      convergence_threshold <= THRESHOLD_RST;
    end else if (write_enable) begin
      case (reg_index)
        REG_NODE_COUNT: node_count            <= write_data[NCNT_W-1:0];
        REG_DAMPING:    damping_factor        <= write_data[BETA_W-1:0];
        REG_ITER_LIMIT: iteration_limit       <= write_data[ITER_W-1:0];
        REG_THRESHOLD:  convergence_threshold <= write_data;
        default:        node_count            <= node_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i               <= '0;
      e               <= '0;
      iters           <= '0;
      edge_total      <= '0;
      overflow_flag   <= 1'b0;
      last_iterations <= '0;
      last_converged  <= 1'b0;
    end else begin
      case (state)
        S_CLR_ALL, S_CLR_DEG: i <= clr_last ? '0 : i + NCW'(1);
        S_IDLE: begin
          if (accept) begin
            a_reg <= first_node;
            a_ok  <= a_in;
            case (mode)
              MODE_LOAD_EDGE: begin
                if (a_in && b_in) begin
                  if (32'(edge_total) < EMAX) begin
                    edge_total <= edge_total + ETW'(1);
                  end else begin
                    overflow_flag <= 1'b1;
                  end
                end
              end
              MODE_RUN: begin
                i        <= '0;
                iters    <= '0;
                dead_sum <= '0;
                diff_sum <= '0;
              end
              MODE_CLEAR: begin
                i             <= '0;
                edge_total    <= '0;
                overflow_flag <= 1'b0;
              end
              default: a_ok <= a_in;
            endcase
          end
        end
        S_A_CHK: begin
          if (deg_rd == '0) begin
            dead_sum <= dead_sum + DSW'(rank_rd);
            i        <= i_last ? '0 : i + NCW'(1);
          end
        end
        S_A_DIV: if (div_done) i <= i_last ? '0 : i + NCW'(1);
        S_B_DEADW: if (div_done) dead <= div_q[RANK_W-1:0];
        S_B_TELW: begin
          if (div_done) begin
            teleport <= div_q[RANK_W-1:0];
            e        <= '0;
            i        <= '0;
          end
        end
        S_C_ADD: e <= e + ETW'(1);
        S_D_SUM: begin
          sum_reg  <= acc_rd + AW'(dead);
          old_rank <= rank_rd;
        end
        S_D_MUL: prod <= PW'(sum_reg) * PW'(beta);
        S_D_NEW: v_reg <= (v_sum[NVW-1:RANK_W] != '0) ? '1 : v_sum[RANK_W-1:0];
        S_D_DIFF: d_reg <= (v_reg >= old_rank) ? v_reg - old_rank : old_rank - v_reg;
        S_D_SQ: sq_reg <= THR_W'(d_reg) * THR_W'(d_reg);
        S_D_ACC: begin
          // The squared-change sum saturates instead of wrapping.
          diff_sum <= diff_add[THR_W] ? '1 : diff_add[THR_W-1:0];
          i        <= i_last ? '0 : i + NCW'(1);
        end
        S_ITER: begin
          iters    <= iters_inc;
          i        <= '0;
          dead_sum <= '0;
          diff_sum <= '0;
          if (iters_inc >= limit) begin
            last_iterations <= iters_inc;
            last_converged  <= 1'b0;
          end else if (diff_sum <= convergence_threshold) begin
            last_iterations <= iters_inc;
            last_converged  <= 1'b1;
          end
        end
        default: e <= e;
      endcase
    end
  end

  assign result_valid    = (state == S_READ) || (state == S_REPORT);
  assign kind            = (state == S_REPORT) ? KIND_RUN : KIND_READ;
  assign node_out        = (state == S_READ) ? a_reg : '0;
  assign rank_out        = ((state == S_READ) && a_ok) ? rank_rd : '0;
  assign iterations_used = last_iterations;
  assign converged       = last_converged;
  assign overflow        = overflow_flag;

endmodule

// ----- src/prc_checker.sv -----
// Port-level checks on the PageRank power-iteration core, bound to the top level.
`timescale 1ns / 1ps
module prc_checker import prc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [MODE_W-1:0] mode,
  input logic              result_valid,
  input logic              kind,
  input logic [NODE_W-1:0] node_out,
  input logic [RANK_W-1:0] rank_out
);

  // A result is only shown while a request is still being finished.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result strobe while idle");

  a_result_pulse: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result strobe held");

  a_read_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == MODE_READ_RANK)) |=> (result_valid && (kind == KIND_READ)))
    else $error("rank read not answered in the next cycle");

  a_rank_load: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == MODE_LOAD_RANK)) |=> !busy)
    else $error("rank load did not complete in one cycle");

  a_run_report: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (kind == KIND_RUN)) |-> ((node_out == '0) && (rank_out == '0)))
    else $error("run report carries node data");

endmodule

bind pagerank_power_iteration_core prc_checker u_prc_checker (.*);

// ----- sim/pagerank_power_iteration_core_test.sv -----
// Self-checking testbench of the PageRank power-iteration core with its own rank predictor.
`timescale 1ns / 1ps
module pagerank_power_iteration_core_test;
  import prc_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] node;
    logic [RANK_W-1:0] rank;
    logic [ITER_W-1:0] iters;
    logic              conv;
    logic              ovf;
  } report_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [RANK_W-1:0] r;
    logic              typed;
    report_t           exp;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [MODE_W-1:0]  mode = '0;
  logic [NODE_W-1:0]  first_node = '0;
  logic [NODE_W-1:0]  second_node = '0;
  logic [RANK_W-1:0]  rank_in = '0;
  logic               write_enable = 1'b0;
  logic [INDEX_W-1:0] reg_index = '0;
  logic [THR_W-1:0]   write_data = '0;
  logic               result_valid;
  logic               kind;
  logic [NODE_W-1:0]  node_out;
  logic [RANK_W-1:0]  rank_out;
  logic [ITER_W-1:0]  iterations_used;
  logic               converged;
  logic               overflow;

  pagerank_power_iteration_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .first_node(first_node), .second_node(second_node), .rank_in(rank_in),
    .write_enable(write_enable), .reg_index(reg_index), .write_data(write_data),
    .result_valid(result_valid), .kind(kind), .node_out(node_out), .rank_out(rank_out),
    .iterations_used(iterations_used), .converged(converged), .overflow(overflow)
  );

  always #5 clk = ~clk;

  initial begin
    #200ms;
    $display("== FAIL ==");
    $finish;
  end

  // Predictor state.
  logic [NCNT_W-1:0] cfg_nodes = NODE_COUNT_RST;
  logic [BETA_W-1:0] cfg_beta = DAMPING_RST;
  logic [ITER_W-1:0] cfg_limit = ITER_LIMIT_RST;
  logic [THR_W-1:0]  cfg_thr = THRESHOLD_RST;
  logic [NODE_W-1:0] src_of [EDGE_MAX_DEF];
  logic [NODE_W-1:0] dst_of [EDGE_MAX_DEF];
  int unsigned       edges_held = 0;
  logic [DEG_W-1:0]  fanout [NODE_MAX_DEF];
  logic [RANK_W-1:0] rank_cur [NODE_MAX_DEF];
  logic [RANK_W-1:0] rank_upd [NODE_MAX_DEF];
  logic [RANK_W-1:0] share [NODE_MAX_DEF];
  logic [63:0]       inflow [NODE_MAX_DEF];
  logic              dropped = 1'b0;
  logic [ITER_W-1:0] run_iters = '0;
  logic              run_conv = 1'b0;

  report_t pending_reports[$];
  int      mismatches = 0;
  bit      failed = 1'b0;
  bit      no_gaps = 1'b0;
  row_t    directed[$];

  initial begin
    for (int i = 0; i < NODE_MAX_DEF; i++) begin
      fanout[i] = '0;
      rank_cur[i] = '0;
    end
  end

  function automatic int unsigned used_nodes();
    if (cfg_nodes == 0) return 1;
    if (cfg_nodes > NODE_MAX_DEF) return NODE_MAX_DEF;
    return cfg_nodes;
  endfunction

  // One power step; returns the saturated sum of squared rank changes.
  function automatic logic [63:0] power_step(int unsigned n, logic [63:0] beta);
    logic [63:0] dead_sum, dead, tele, diff_sum, v, d, sq;
    dead_sum = 0;
    diff_sum = 0;
    for (int i = 0; i < n; i++) begin
      if (fanout[i] == 0) begin
        share[i] = 0;
        dead_sum += rank_cur[i];
      end else begin
        share[i] = rank_cur[i] / fanout[i];
      end
      inflow[i] = 0;
    end
    dead = dead_sum / n;
    tele = ((64'd32768 - beta) << 16) / n;
    for (int e = 0; e < edges_held; e++)
      if (src_of[e] < n && dst_of[e] < n) inflow[dst_of[e]] += share[src_of[e]];
    for (int i = 0; i < n; i++) begin
      v = (((inflow[i] + dead) * beta) >> 15) + tele;
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      rank_upd[i] = v[31:0];
      d = (v >= rank_cur[i]) ? v - rank_cur[i] : rank_cur[i] - v;
      sq = d * d;
      diff_sum = (diff_sum > ~64'd0 - sq) ? ~64'd0 : diff_sum + sq;
    end
    for (int i = 0; i < n; i++) rank_cur[i] = rank_upd[i];
    return diff_sum;
  endfunction

  // Applies one accepted request to the predictor; returns 1 when it yields a report.
  function automatic bit apply_request(logic [MODE_W-1:0] m, logic [NODE_W-1:0] a,
                                       logic [NODE_W-1:0] b, logic [RANK_W-1:0] r,
                                       output report_t rep);
    int unsigned n, limit, iters;
    logic [63:0] beta, s;
    rep = '0;
    case (m)
      MODE_LOAD_EDGE: begin
        if (edges_held >= EDGE_MAX_DEF) begin
          dropped = 1'b1;
        end else begin
          src_of[edges_held] = a;
          dst_of[edges_held] = b;
          edges_held++;
          if (fanout[a] < DEG_SAT) fanout[a]++;
        end
        return 0;
      end
      MODE_LOAD_RANK: begin
        rank_cur[a] = r;
        return 0;
      end
      MODE_RUN: begin
        n = used_nodes();
        beta = (cfg_beta > BETA_ONE) ? BETA_ONE : cfg_beta;
        limit = (cfg_limit == 0) ? 1 : cfg_limit;
        iters = 0;
        run_conv = 1'b0;
        forever begin
          s = power_step(n, beta);
          iters++;
          if (iters >= limit) break;
          if (s <= cfg_thr) begin
            run_conv = 1'b1;
            break;
          end
        end
        run_iters = iters[ITER_W-1:0];
        rep = '{KIND_RUN, '0, '0, run_iters, run_conv, dropped};
        return 1;
      end
      MODE_READ_RANK: begin
        rep = '{KIND_READ, a, rank_cur[a], run_iters, run_conv, dropped};
        return 1;
      end
      MODE_CLEAR: begin
        edges_held = 0;
        for (int i = 0; i < NODE_MAX_DEF; i++) fanout[i] = '0;
        dropped = 1'b0;
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (no_gaps) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Issues one request; a typed expectation, when given, replaces the predicted one.
  task automatic send_request(logic [MODE_W-1:0] m, logic [NODE_W-1:0] a,
                              logic [NODE_W-1:0] b, logic [RANK_W-1:0] r,
                              bit typed = 0, report_t typed_rep = '0);
    report_t rep;
    bit has_rep;
    repeat (pick_gap()) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    mode = m;
    first_node = a;
    second_node = b;
    rank_in = r;
    do @(posedge clk); while (busy);
    has_rep = apply_request(m, a, b, r, rep);
    if (has_rep) pending_reports.insert(pending_reports.size(), typed ? typed_rep : rep);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [THR_W-1:0] val);
    @(negedge clk);
    write_enable = 1'b1;
    reg_index = idx;
    write_data = val;
    case (idx)
      REG_NODE_COUNT: cfg_nodes = val[NCNT_W-1:0];
      REG_DAMPING:    cfg_beta = val[BETA_W-1:0];
      REG_ITER_LIMIT: cfg_limit = val[ITER_W-1:0];
      REG_THRESHOLD:  cfg_thr = val;
      default:        ;
    endcase
    @(negedge clk);
    write_enable = 1'b0;
  endtask

  task automatic set_config(logic [THR_W-1:0] n, logic [THR_W-1:0] beta,
                            logic [THR_W-1:0] limit, logic [THR_W-1:0] thr);
    wait_idle();
    write_reg(REG_NODE_COUNT, n);
    write_reg(REG_DAMPING, beta);
    write_reg(REG_ITER_LIMIT, limit);
    write_reg(REG_THRESHOLD, thr);
  endtask

  function automatic logic [NODE_W-1:0] pick_node();
    if ($urandom_range(0, 99) < 85) return NODE_W'($urandom_range(0, used_nodes() - 1));
    return NODE_W'($urandom_range(0, NODE_MAX_DEF - 1));
  endfunction

  function automatic logic [RANK_W-1:0] pick_rank();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return $urandom_range(0, 32'h8000_0000 / used_nodes());
    endcase
  endfunction

  task automatic random_requests(int unsigned count);
    int unsigned p;
    logic [NODE_W-1:0] ra, rb;
    logic [RANK_W-1:0] rr;
    for (int k = 0; k < count; k++) begin
      p = $urandom_range(0, 99);
      ra = NODE_W'($urandom());
      rb = NODE_W'($urandom());
      rr = $urandom();
      if (p < 45)      send_request(MODE_LOAD_EDGE, pick_node(), pick_node(), rr);
      else if (p < 63) send_request(MODE_LOAD_RANK, pick_node(), rb, pick_rank());
      else if (p < 71) send_request(MODE_RUN, ra, rb, rr);
      else if (p < 94) send_request(MODE_READ_RANK, pick_node(), rb, rr);
      else if (p < 96) send_request(MODE_CLEAR, ra, rb, rr);
      else             send_request(MODE_W'($urandom_range(5, 7)), ra, rb, rr);
    end
  endtask

  function automatic row_t mk(logic [MODE_W-1:0] m, logic [NODE_W-1:0] a,
                              logic [NODE_W-1:0] b, logic [RANK_W-1:0] r,
                              logic typed = 0, logic [RANK_W-1:0] exp_rank = 0);
    return '{m, a, b, r, typed, '{KIND_READ, a, exp_rank, '0, 1'b0, 1'b0}};
  endfunction

  always @(posedge clk) begin
    report_t want;
    if (!rst && result_valid) begin
      if (pending_reports.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = pending_reports.pop_front();
        if (kind !== want.kind || node_out !== want.node || rank_out !== want.rank ||
            iterations_used !== want.iters || converged !== want.conv ||
            overflow !== want.ovf) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch %0t exp k%0d n%0d r%h i%0d c%0d o%0d got k%0d n%0d r%h i%0d c%0d o%0d",
                     $realtime, want.kind, want.node, want.rank, want.iters, want.conv,
                     want.ovf, kind, node_out, rank_out, iterations_used, converged,
                     overflow);
        end
      end
    end
  end

  initial begin
    logic [THR_W-1:0] thr;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Small graph first: a run at the reset settings would walk every node many times.
    set_config(4, DAMPING_RST, 3, 0);
    directed.insert(directed.size(), mk(MODE_READ_RANK, 0, 0, 0, 1, 0));
    directed.insert(directed.size(), mk(MODE_READ_RANK, 1023, 0, 0, 1, 0));
    directed.insert(directed.size(), mk(3'd5, 1, 2, 32'hFFFF_FFFF));
    directed.insert(directed.size(), mk(3'd7, 1023, 1023, 0));
    directed.insert(directed.size(), mk(MODE_LOAD_RANK, 1023, 0, 32'h8000_0000));
    directed.insert(directed.size(), mk(MODE_READ_RANK, 1023, 0, 0, 1, 32'h8000_0000));
    directed.insert(directed.size(), mk(MODE_LOAD_RANK, 0, 1023, 32'hFFFF_FFFF));
    directed.insert(directed.size(), mk(MODE_READ_RANK, 0, 0, 0, 1, 32'hFFFF_FFFF));
    directed.insert(directed.size(), mk(MODE_LOAD_RANK, 1, 0, 32'h4000_0000));
    directed.insert(directed.size(), mk(MODE_LOAD_EDGE, 0, 1, 0));
    directed.insert(directed.size(), mk(MODE_LOAD_EDGE, 1, 2, 0));
    directed.insert(directed.size(), mk(MODE_LOAD_EDGE, 1, 0, 0));
    directed.insert(directed.size(), mk(MODE_LOAD_EDGE, 2, 2, 0));
    // Endpoints past the node count are stored but never spread.
    directed.insert(directed.size(), mk(MODE_LOAD_EDGE, 3, 1023, 0));
    directed.insert(directed.size(), mk(MODE_LOAD_EDGE, 1023, 0, 0));
    directed.insert(directed.size(), mk(MODE_RUN, 0, 0, 0));
    directed.insert(directed.size(), mk(MODE_READ_RANK, 0, 0, 0));
    directed.insert(directed.size(), mk(MODE_READ_RANK, 1, 0, 0));
    directed.insert(directed.size(), mk(MODE_READ_RANK, 2, 0, 0));
    directed.insert(directed.size(), mk(MODE_READ_RANK, 3, 0, 0));
    directed.insert(directed.size(), mk(MODE_READ_RANK, 1023, 0, 0));
    directed.insert(directed.size(), mk(MODE_CLEAR, 0, 0, 0));
    directed.insert(directed.size(), mk(MODE_RUN, 0, 0, 0));
    directed.insert(directed.size(), mk(MODE_READ_RANK, 3, 0, 0));
    foreach (directed[k])
      send_request(directed[k].mode, directed[k].a, directed[k].b, directed[k].r,
                   directed[k].typed, directed[k].exp);

    // Random phases over a spread of settings.
    for (int ph = 0; ph < 13; ph++) begin
      case ($urandom_range(0, 4))
        0: thr = 0;
        1: thr = ~64'd0;
        2: thr = {$urandom(), $urandom()};
        default: thr = 64'd1 << $urandom_range(30, 62);
      endcase
      set_config(ph == 0 ? 1 : (ph == 1 ? 2 : $urandom_range(1, 16)),
                 ph == 2 ? 0 : (ph == 3 ? 32768 : (ph == 4 ? 16'hFFFF : $urandom_range(0, 32768))),
                 ph == 5 ? 65535 : $urandom_range(1, 8),
                 ph == 5 ? ~64'd0 : thr);
      no_gaps = (ph % 4 == 3);
      random_requests(125);
    end

    // Widest graph: node count above the store size acts as the full store.
    set_config(11'h7FF, 27853, 2, 0);
    no_gaps = 1'b0;
    for (int k = 0; k < 20; k++)
      send_request(MODE_LOAD_EDGE, NODE_W'($urandom()), NODE_W'($urandom()), 0);
    send_request(MODE_LOAD_RANK, 1023, 0, $urandom());
    send_request(MODE_RUN, 0, 0, 0);
    send_request(MODE_READ_RANK, 1023, 0, 0);
    set_config(1024, 27853, 1, 0);
    send_request(MODE_RUN, 0, 0, 0);
    send_request(MODE_READ_RANK, NODE_W'($urandom()), 0, 0);

    // Dense graph on a few nodes, some edges reaching past the node count; then a clear.
    set_config(8, 30000, 1, 0);
    send_request(MODE_CLEAR, 0, 0, 0);
    for (int k = 0; k < 40; k++)
      send_request(MODE_LOAD_EDGE, NODE_W'($urandom_range(0, 9)),
                   NODE_W'($urandom_range(0, 9)), 0);
    send_request(MODE_RUN, 0, 0, 0);
    send_request(MODE_READ_RANK, 2, 0, 0);
    send_request(MODE_CLEAR, 0, 0, 0);
    send_request(MODE_READ_RANK, 2, 0, 0);
    random_requests(60);

    wait_idle();
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
